// File: sv/cspl_pkg.sv
// Shared types, constants and the arithmetic program of the cubic spline evaluator.
// Used by cspl_alu and cubic_spline_evaluator; depends on nothing.
package cspl_pkg;

   localparam int DEF_MAX_KNOTS = 256;
   localparam int DEF_FRAC_BITS = 16;

   localparam logic [61:0]        SAT_MAG = {62{1'b1}};
   localparam logic signed [63:0] SAT_POS = $signed({2'b00, SAT_MAG});

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MULQ,
      OP_MULK,
      OP_DIVQ,
      OP_DIVK
   } alu_op_type;

   typedef enum logic [2:0] {
      AS_IDLE,
      AS_MUL,
      AS_MUL_END,
      AS_DIV,
      AS_DIV_END,
      AS_FIN
   } alu_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_SRCH,
      ST_CMP,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_FETCH_C,
      ST_SETUP,
      ST_ISSUE,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      SRC_X, SRC_H, SRC_F0, SRC_F1, SRC_M0, SRC_M1,
      SRC_ONE, SRC_ZERO, SRC_K2, SRC_K3, SRC_K6,
      SRC_T, SRC_X2H, SRC_X3H, SRC_XX, SRC_XH,
      SRC_A, SRC_C, SRC_D, SRC_BP, SRC_AP, SRC_CP, SRC_DP,
      SRC_T1, SRC_T2, SRC_S1, SRC_VAL, SRC_SLOPE
   } src_type;

   typedef struct packed {
      alu_op_type op;
      src_type    src_a;
      src_type    src_b;
      src_type    dst;
   } instr_type;

   typedef struct packed {
      logic               start;
      alu_op_type         op;
      logic signed [63:0] opa;
      logic signed [63:0] opb;
   } alu_cmd_type;

   typedef struct packed {
      logic               done;
      logic               clip;
      logic signed [63:0] result;
   } alu_rsp_type;

   localparam logic [5:0] PROG_LAST = 6'd37;

   function automatic instr_type prog_at(input logic [5:0] pc);
      instr_type ins;
      case (pc)
         6'd0:  ins = '{OP_DIVQ, SRC_X,   SRC_H,   SRC_T};
         6'd1:  ins = '{OP_MULQ, SRC_X,   SRC_T,   SRC_X2H};
         6'd2:  ins = '{OP_MULQ, SRC_X2H, SRC_X,   SRC_X3H};
         6'd3:  ins = '{OP_MULQ, SRC_X,   SRC_X,   SRC_XX};
         6'd4:  ins = '{OP_MULQ, SRC_X,   SRC_H,   SRC_XH};
         6'd5:  ins = '{OP_SUB,  SRC_ONE, SRC_T,   SRC_A};
         6'd6:  ins = '{OP_MULK, SRC_XX,  SRC_K3,  SRC_T1};
         6'd7:  ins = '{OP_SUB,  SRC_T1,  SRC_X3H, SRC_T1};
         6'd8:  ins = '{OP_MULK, SRC_XH,  SRC_K2,  SRC_T2};
         6'd9:  ins = '{OP_SUB,  SRC_T1,  SRC_T2,  SRC_T1};
         6'd10: ins = '{OP_DIVK, SRC_T1,  SRC_K6,  SRC_C};
         6'd11: ins = '{OP_SUB,  SRC_X3H, SRC_XH,  SRC_T1};
         6'd12: ins = '{OP_DIVK, SRC_T1,  SRC_K6,  SRC_D};
         6'd13: ins = '{OP_DIVQ, SRC_ONE, SRC_H,   SRC_BP};
         6'd14: ins = '{OP_SUB,  SRC_ZERO, SRC_BP, SRC_AP};
         6'd15: ins = '{OP_MULK, SRC_X,   SRC_K6,  SRC_T1};
         6'd16: ins = '{OP_MULK, SRC_X2H, SRC_K3,  SRC_T2};
         6'd17: ins = '{OP_SUB,  SRC_T1,  SRC_T2,  SRC_T1};
         6'd18: ins = '{OP_MULK, SRC_H,   SRC_K2,  SRC_T2};
         6'd19: ins = '{OP_SUB,  SRC_T1,  SRC_T2,  SRC_T1};
         6'd20: ins = '{OP_DIVK, SRC_T1,  SRC_K6,  SRC_CP};
         6'd21: ins = '{OP_MULK, SRC_X2H, SRC_K3,  SRC_T1};
         6'd22: ins = '{OP_SUB,  SRC_T1,  SRC_H,   SRC_T1};
         6'd23: ins = '{OP_DIVK, SRC_T1,  SRC_K6,  SRC_DP};
         6'd24: ins = '{OP_MULQ, SRC_A,   SRC_F0,  SRC_T1};
         6'd25: ins = '{OP_MULQ, SRC_T,   SRC_F1,  SRC_T2};
         6'd26: ins = '{OP_ADD,  SRC_T1,  SRC_T2,  SRC_S1};
         6'd27: ins = '{OP_MULQ, SRC_C,   SRC_M0,  SRC_T1};
         6'd28: ins = '{OP_MULQ, SRC_D,   SRC_M1,  SRC_T2};
         6'd29: ins = '{OP_ADD,  SRC_T1,  SRC_T2,  SRC_T1};
         6'd30: ins = '{OP_ADD,  SRC_S1,  SRC_T1,  SRC_VAL};
         6'd31: ins = '{OP_MULQ, SRC_AP,  SRC_F0,  SRC_T1};
         6'd32: ins = '{OP_MULQ, SRC_BP,  SRC_F1,  SRC_T2};
         6'd33: ins = '{OP_ADD,  SRC_T1,  SRC_T2,  SRC_S1};
         6'd34: ins = '{OP_MULQ, SRC_CP,  SRC_M0,  SRC_T1};
         6'd35: ins = '{OP_MULQ, SRC_DP,  SRC_M1,  SRC_T2};
         6'd36: ins = '{OP_ADD,  SRC_T1,  SRC_T2,  SRC_T1};
         6'd37: ins = '{OP_ADD,  SRC_S1,  SRC_T1,  SRC_SLOPE};
         default: ins = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_T1};
      endcase
      return ins;
   endfunction

endpackage

// File: sv/cspl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cspl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/cspl_alu.sv
// Shared saturating fixed-point unit: add and subtract, multiply over four 31x31 partial
// products, restoring divide one quotient bit a cycle, divide by six through a
// reciprocal multiply on the same partial-product path. Depends on cspl_pkg.
module cspl_alu #(
   parameter int FRAC_BITS = cspl_pkg::DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cspl_pkg::alu_cmd_type cmd,
   output cspl_pkg::alu_rsp_type rsp
);

   localparam logic [61:0]  DIVQ_LIM   = cspl_pkg::SAT_MAG >> FRAC_BITS;
   localparam logic [123:0] ROUND_HALF = 124'(1) << (FRAC_BITS - 1);
   localparam logic [61:0]  RECIP3     = 62'h2AAA_AAAA_AAAA_AAAB;

   cspl_pkg::alu_state_type state_ff, state_in;
   cspl_pkg::alu_op_type    op_ff, op_in;
   logic                    neg_ff, neg_in;
   logic [61:0]             ua_ff, ua_in, ub_ff, ub_in, rem_ff, rem_in;
   logic [123:0]            acc_ff, acc_in;
   logic [62:0]             quo_ff, quo_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic signed [63:0]      res_ff, res_in;
   logic                    clip_ff, clip_in;

   logic [61:0]        a_mag, b_mag, fin_mag;
   logic signed [63:0] sum;
   logic [30:0]        mul_a, mul_b;
   logic [61:0]        pp;
   logic [123:0]       pp_ext, acc_rnd;
   logic [62:0]        rem_try;

   assign a_mag = cmd.opa[63] ? 62'(-cmd.opa) : 62'(cmd.opa);
   assign b_mag = cmd.opb[63] ? 62'(-cmd.opb) : 62'(cmd.opb);
   assign sum   = (cmd.op == cspl_pkg::OP_SUB) ? cmd.opa - cmd.opb : cmd.opa + cmd.opb;
   assign mul_a = cnt_ff[1] ? ua_ff[61:31] : ua_ff[30:0];
   assign mul_b = cnt_ff[0] ? ub_ff[61:31] : ub_ff[30:0];
   assign pp    = mul_a * mul_b;
   assign acc_rnd = (acc_ff + ROUND_HALF) >> FRAC_BITS;
   assign rem_try = {rem_ff, quo_ff[62]};

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:       pp_ext = 124'(pp);
         2'd1, 2'd2: pp_ext = 124'(pp) << 31;
         default:    pp_ext = 124'(pp) << 62;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cspl_pkg::AS_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  cspl_pkg::OP_ADD, cspl_pkg::OP_SUB: state_in = cspl_pkg::AS_FIN;
                  cspl_pkg::OP_MULQ, cspl_pkg::OP_MULK, cspl_pkg::OP_DIVK: begin
                     state_in = cspl_pkg::AS_MUL;
                  end
                  cspl_pkg::OP_DIVQ: begin
                     state_in = (a_mag > DIVQ_LIM) ? cspl_pkg::AS_FIN : cspl_pkg::AS_DIV;
                  end
                  default: state_in = cspl_pkg::AS_IDLE;
               endcase
            end
         end
         cspl_pkg::AS_MUL: begin
            if (cnt_ff == 6'd3) begin
               state_in = cspl_pkg::AS_MUL_END;
            end
         end
         cspl_pkg::AS_MUL_END: state_in = cspl_pkg::AS_FIN;
         cspl_pkg::AS_DIV: begin
            if (cnt_ff == 6'd62) begin
               state_in = cspl_pkg::AS_DIV_END;
            end
         end
         cspl_pkg::AS_DIV_END: state_in = cspl_pkg::AS_FIN;
         cspl_pkg::AS_FIN: state_in = cspl_pkg::AS_IDLE;
         default: state_in = cspl_pkg::AS_IDLE;
      endcase
   end

   always_comb begin
      op_in   = op_ff;
      neg_in  = neg_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      clip_in = clip_ff;
      fin_mag = '0;
      case (state_ff)
         cspl_pkg::AS_IDLE: begin
            if (cmd.start) begin
               op_in   = cmd.op;
               neg_in  = cmd.opa[63] ^ cmd.opb[63];
               ua_in   = a_mag;
               ub_in   = b_mag;
               acc_in  = '0;
               rem_in  = '0;
               cnt_in  = '0;
               clip_in = 1'b0;
               case (cmd.op)
                  cspl_pkg::OP_ADD, cspl_pkg::OP_SUB: begin
                     if (sum > cspl_pkg::SAT_POS) begin
                        res_in  = cspl_pkg::SAT_POS;
                        clip_in = 1'b1;
                     end else if (sum < -cspl_pkg::SAT_POS) begin
                        res_in  = -cspl_pkg::SAT_POS;
                        clip_in = 1'b1;
                     end else begin
                        res_in = sum;
                     end
                  end
                  cspl_pkg::OP_DIVQ: begin
                     if (a_mag > DIVQ_LIM) begin
                        res_in  = (cmd.opa[63] ^ cmd.opb[63]) ? -cspl_pkg::SAT_POS
                                                              : cspl_pkg::SAT_POS;
                        clip_in = 1'b1;
                     end else begin
                        quo_in = 63'({1'b0, a_mag} << FRAC_BITS) + 63'(b_mag >> 1);
                     end
                  end
                  cspl_pkg::OP_DIVK: begin
                     ua_in = 62'((63'(a_mag) + 63'd3) >> 1);
                     ub_in = RECIP3;
                  end
                  default: ;
               endcase
            end
         end
         cspl_pkg::AS_MUL: begin
            acc_in = acc_ff + pp_ext;
            cnt_in = cnt_ff + 6'd1;
         end
         cspl_pkg::AS_MUL_END: begin
            if (op_ff == cspl_pkg::OP_DIVK) begin
               fin_mag = 62'(acc_ff[123:63]);
            end else if (acc_ff > 124'(cspl_pkg::SAT_MAG)) begin
               fin_mag = cspl_pkg::SAT_MAG;
               clip_in = 1'b1;
            end else if (op_ff == cspl_pkg::OP_MULQ) begin
               fin_mag = acc_rnd[61:0];
            end else begin
               fin_mag = acc_ff[61:0];
            end
            res_in = neg_ff ? -$signed({2'b00, fin_mag}) : $signed({2'b00, fin_mag});
         end
         cspl_pkg::AS_DIV: begin
            if (rem_try >= {1'b0, ub_ff}) begin
               rem_in = 62'(rem_try - {1'b0, ub_ff});
               quo_in = {quo_ff[61:0], 1'b1};
            end else begin
               rem_in = rem_try[61:0];
               quo_in = {quo_ff[61:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
         end
         cspl_pkg::AS_DIV_END: begin
            if (quo_ff > {1'b0, cspl_pkg::SAT_MAG}) begin
               fin_mag = cspl_pkg::SAT_MAG;
               clip_in = 1'b1;
            end else begin
               fin_mag = quo_ff[61:0];
            end
            res_in = neg_ff ? -$signed({2'b00, fin_mag}) : $signed({2'b00, fin_mag});
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.done   = (state_ff == cspl_pkg::AS_FIN);
      rsp.clip   = clip_ff;
      rsp.result = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cspl_pkg::AS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      clip_ff <= clip_in;
   end

endmodule

// File: sv/cubic_spline_evaluator.sv
// Cubic spline evaluator, moment form: knot table in RAM, binary interval search,
// 38-step program on the shared unit cspl_alu. Depends on cspl_pkg, cspl_ram, cspl_alu.
// Load word: accepted while idle, table written in the same cycle. Evaluate word: bound
// checks, k = ceil(log2(N-1)) search halvings, knot fetches, setup, then the program:
// two divides, 22 multiplies (four divide by six), 14 adds or subtracts. One evaluate at a time,
// req_stall high until its result is in the output register. Reset: knot_count returns to 3.
module cubic_spline_evaluator #(
   parameter int MAX_KNOTS = cspl_pkg::DEF_MAX_KNOTS,
   parameter int FRAC_BITS = cspl_pkg::DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [7:0]         req_knot_index,
   input  logic signed [31:0] req_knot_position,
   input  logic signed [31:0] req_knot_value,
   input  logic signed [31:0] req_knot_curvature,
   input  logic signed [31:0] req_query_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_spline_value,
   output logic signed [31:0] rsp_spline_slope,
   output logic [7:0]         rsp_interval_used,
   output logic               rsp_outside_grid,
   output logic               rsp_saturated,
   input  logic               csr_wr_en,
   input  logic [8:0]         csr_wr_data
);

   localparam int AW  = $clog2(MAX_KNOTS);
   localparam int CW  = $clog2(MAX_KNOTS + 1);
   localparam int NW  = (CW > 9) ? CW : 9;
   localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] VMAX  = 64'sd2147483647;
   localparam logic signed [63:0] VMIN  = -64'sd2147483648;

   cspl_pkg::state_type state_ff, state_in;

   logic [8:0]         knot_count_ff, knot_count_in;
   logic signed [31:0] q_ff, q_in, gi_ff, gi_in;
   logic [AW-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, i_ff, i_in;
   logic               outside_ff, outside_in, degen_ff, degen_in, clip_ff, clip_in;
   logic [5:0]         pc_ff, pc_in;
   logic signed [63:0] x_ff, x_in, h_ff, h_in, f0_ff, f0_in, f1_ff, f1_in;
   logic signed [63:0] m0_ff, m0_in, m1_ff, m1_in;
   logic signed [63:0] t_ff, t_in, x2h_ff, x2h_in, x3h_ff, x3h_in, xx_ff, xx_in;
   logic signed [63:0] xh_ff, xh_in, a_ff, a_in, c_ff, c_in, d_ff, d_in;
   logic signed [63:0] bp_ff, bp_in, ap_ff, ap_in, cp_ff, cp_in, dp_ff, dp_in;
   logic signed [63:0] t1_ff, t1_in, t2_ff, t2_in, s1_ff, s1_in;
   logic signed [63:0] val_ff, val_in, slope_ff, slope_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_sat_ff, rsp_sat_in;
   logic               rsp_out_ff, rsp_out_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in, rsp_slope_ff, rsp_slope_in;
   logic [7:0]         rsp_int_ff, rsp_int_in;

   logic [NW-1:0]      cnt_ext, n_eff;
   logic [AW-1:0]      last_idx, mid, rd_addr;
   logic               wr_en;
   logic [95:0]        rd_data;
   logic signed [31:0] rd_grid, rd_value, rd_curv;
   logic               out_free;
   cspl_pkg::instr_type   ins;
   cspl_pkg::alu_cmd_type alu_cmd;
   cspl_pkg::alu_rsp_type alu_rsp;

   cspl_ram #(
      .WIDTH (96),
      .DEPTH (MAX_KNOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_knot_index)),
      .wr_data ({req_knot_position, req_knot_value, req_knot_curvature}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cspl_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

   assign rd_grid  = rd_data[95:64];
   assign rd_value = rd_data[63:32];
   assign rd_curv  = rd_data[31:0];
   assign mid      = AW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign ins      = cspl_pkg::prog_at(pc_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wr_en    = (state_ff == cspl_pkg::ST_IDLE) && req_valid && !req_action &&
                     ({24'd0, req_knot_index} < 32'(MAX_KNOTS));

   always_comb begin
      cnt_ext = NW'(knot_count_ff);
      if (cnt_ext < NW'(3)) begin
         n_eff = NW'(3);
      end else if (cnt_ext > NW'(MAX_KNOTS)) begin
         n_eff = NW'(MAX_KNOTS);
      end else begin
         n_eff = cnt_ext;
      end
      last_idx = AW'(n_eff - NW'(1));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cspl_pkg::ST_IDLE: begin
            if (req_valid && req_action) begin
               state_in = cspl_pkg::ST_LO;
            end
         end
         cspl_pkg::ST_LO: begin
            state_in = (q_ff < rd_grid) ? cspl_pkg::ST_FETCH_A : cspl_pkg::ST_HI;
         end
         cspl_pkg::ST_HI: begin
            state_in = (q_ff > rd_grid) ? cspl_pkg::ST_FETCH_A : cspl_pkg::ST_SRCH;
         end
         cspl_pkg::ST_SRCH: begin
            state_in = ((hi_ff - lo_ff) > AW'(1)) ? cspl_pkg::ST_CMP : cspl_pkg::ST_FETCH_A;
         end
         cspl_pkg::ST_CMP:     state_in = cspl_pkg::ST_SRCH;
         cspl_pkg::ST_FETCH_A: state_in = cspl_pkg::ST_FETCH_B;
         cspl_pkg::ST_FETCH_B: state_in = cspl_pkg::ST_FETCH_C;
         cspl_pkg::ST_FETCH_C: state_in = cspl_pkg::ST_SETUP;
         cspl_pkg::ST_SETUP: begin
            state_in = (h_ff <= 64'sd0) ? cspl_pkg::ST_FINISH : cspl_pkg::ST_ISSUE;
         end
         cspl_pkg::ST_ISSUE: state_in = cspl_pkg::ST_WAIT;
         cspl_pkg::ST_WAIT: begin
            if (alu_rsp.done) begin
               state_in = (pc_ff == cspl_pkg::PROG_LAST) ? cspl_pkg::ST_FINISH
                                                         : cspl_pkg::ST_ISSUE;
            end
         end
         cspl_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = cspl_pkg::ST_IDLE;
            end
         end
         default: state_in = cspl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      alu_cmd.start = (state_ff == cspl_pkg::ST_ISSUE);
      alu_cmd.op    = ins.op;
      case (ins.src_a)
         cspl_pkg::SRC_X:     alu_cmd.opa = x_ff;
         cspl_pkg::SRC_H:     alu_cmd.opa = h_ff;
         cspl_pkg::SRC_ONE:   alu_cmd.opa = ONE_Q;
         cspl_pkg::SRC_ZERO:  alu_cmd.opa = '0;
         cspl_pkg::SRC_T:     alu_cmd.opa = t_ff;
         cspl_pkg::SRC_X2H:   alu_cmd.opa = x2h_ff;
         cspl_pkg::SRC_X3H:   alu_cmd.opa = x3h_ff;
         cspl_pkg::SRC_XX:    alu_cmd.opa = xx_ff;
         cspl_pkg::SRC_XH:    alu_cmd.opa = xh_ff;
         cspl_pkg::SRC_A:     alu_cmd.opa = a_ff;
         cspl_pkg::SRC_C:     alu_cmd.opa = c_ff;
         cspl_pkg::SRC_D:     alu_cmd.opa = d_ff;
         cspl_pkg::SRC_BP:    alu_cmd.opa = bp_ff;
         cspl_pkg::SRC_AP:    alu_cmd.opa = ap_ff;
         cspl_pkg::SRC_CP:    alu_cmd.opa = cp_ff;
         cspl_pkg::SRC_DP:    alu_cmd.opa = dp_ff;
         cspl_pkg::SRC_T1:    alu_cmd.opa = t1_ff;
         cspl_pkg::SRC_S1:    alu_cmd.opa = s1_ff;
         default:             alu_cmd.opa = '0;
      endcase
      case (ins.src_b)
         cspl_pkg::SRC_X:     alu_cmd.opb = x_ff;
         cspl_pkg::SRC_H:     alu_cmd.opb = h_ff;
         cspl_pkg::SRC_F0:    alu_cmd.opb = f0_ff;
         cspl_pkg::SRC_F1:    alu_cmd.opb = f1_ff;
         cspl_pkg::SRC_M0:    alu_cmd.opb = m0_ff;
         cspl_pkg::SRC_M1:    alu_cmd.opb = m1_ff;
         cspl_pkg::SRC_K2:    alu_cmd.opb = 64'sd2;
         cspl_pkg::SRC_K3:    alu_cmd.opb = 64'sd3;
         cspl_pkg::SRC_K6:    alu_cmd.opb = 64'sd6;
         cspl_pkg::SRC_T:     alu_cmd.opb = t_ff;
         cspl_pkg::SRC_X3H:   alu_cmd.opb = x3h_ff;
         cspl_pkg::SRC_XH:    alu_cmd.opb = xh_ff;
         cspl_pkg::SRC_BP:    alu_cmd.opb = bp_ff;
         cspl_pkg::SRC_T1:    alu_cmd.opb = t1_ff;
         cspl_pkg::SRC_T2:    alu_cmd.opb = t2_ff;
         default:             alu_cmd.opb = '0;
      endcase
   end

   always_comb begin
      case (state_ff)
         cspl_pkg::ST_IDLE:    rd_addr = '0;
         cspl_pkg::ST_LO:      rd_addr = last_idx;
         cspl_pkg::ST_SRCH:    rd_addr = mid;
         cspl_pkg::ST_FETCH_B: rd_addr = i_ff + AW'(1);
         default:              rd_addr = i_ff;
      endcase
      req_stall = (state_ff != cspl_pkg::ST_IDLE);
   end

   always_comb begin
      knot_count_in = csr_wr_en ? csr_wr_data : knot_count_ff;
      q_in = q_ff;       gi_in = gi_ff;     lo_in = lo_ff;     hi_in = hi_ff;
      mid_in = mid_ff;   i_in = i_ff;       outside_in = outside_ff;
      degen_in = degen_ff; clip_in = clip_ff; pc_in = pc_ff;
      x_in = x_ff;   h_in = h_ff;   f0_in = f0_ff; f1_in = f1_ff;
      m0_in = m0_ff; m1_in = m1_ff; t_in = t_ff;   x2h_in = x2h_ff;
      x3h_in = x3h_ff; xx_in = xx_ff; xh_in = xh_ff; a_in = a_ff;
      c_in = c_ff;   d_in = d_ff;   bp_in = bp_ff; ap_in = ap_ff;
      cp_in = cp_ff; dp_in = dp_ff; t1_in = t1_ff; t2_in = t2_ff;
      s1_in = s1_ff; val_in = val_ff; slope_in = slope_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_val_in = rsp_val_ff; rsp_slope_in = rsp_slope_ff; rsp_int_in = rsp_int_ff;
      rsp_out_in = rsp_out_ff; rsp_sat_in = rsp_sat_ff;
      case (state_ff)
         cspl_pkg::ST_IDLE: begin
            q_in       = req_query_position;
            outside_in = 1'b0;
         end
         cspl_pkg::ST_LO: begin
            if (q_ff < rd_grid) begin
               i_in       = '0;
               outside_in = 1'b1;
            end
         end
         cspl_pkg::ST_HI: begin
            if (q_ff > rd_grid) begin
               i_in       = last_idx - AW'(1);
               outside_in = 1'b1;
            end else begin
               lo_in = '0;
               hi_in = last_idx;
            end
         end
         cspl_pkg::ST_SRCH: begin
            mid_in = mid;
            i_in   = lo_ff;
         end
         cspl_pkg::ST_CMP: begin
            if (rd_grid <= q_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
         end
         cspl_pkg::ST_FETCH_B: begin
            gi_in = rd_grid;
            f0_in = {{32{rd_value[31]}}, rd_value};
            m0_in = {{32{rd_curv[31]}}, rd_curv};
         end
         cspl_pkg::ST_FETCH_C: begin
            f1_in = {{32{rd_value[31]}}, rd_value};
            m1_in = {{32{rd_curv[31]}}, rd_curv};
            x_in  = {{32{q_ff[31]}}, q_ff} - {{32{gi_ff[31]}}, gi_ff};
            h_in  = {{32{rd_grid[31]}}, rd_grid} - {{32{gi_ff[31]}}, gi_ff};
         end
         cspl_pkg::ST_SETUP: begin
            degen_in = (h_ff <= 64'sd0);
            pc_in    = '0;
            clip_in  = 1'b0;
         end
         cspl_pkg::ST_WAIT: begin
            if (alu_rsp.done) begin
               clip_in = clip_ff | alu_rsp.clip;
               pc_in   = pc_ff + 6'd1;
               case (ins.dst)
                  cspl_pkg::SRC_T:     t_in = alu_rsp.result;
                  cspl_pkg::SRC_X2H:   x2h_in = alu_rsp.result;
                  cspl_pkg::SRC_X3H:   x3h_in = alu_rsp.result;
                  cspl_pkg::SRC_XX:    xx_in = alu_rsp.result;
                  cspl_pkg::SRC_XH:    xh_in = alu_rsp.result;
                  cspl_pkg::SRC_A:     a_in = alu_rsp.result;
                  cspl_pkg::SRC_C:     c_in = alu_rsp.result;
                  cspl_pkg::SRC_D:     d_in = alu_rsp.result;
                  cspl_pkg::SRC_BP:    bp_in = alu_rsp.result;
                  cspl_pkg::SRC_AP:    ap_in = alu_rsp.result;
                  cspl_pkg::SRC_CP:    cp_in = alu_rsp.result;
                  cspl_pkg::SRC_DP:    dp_in = alu_rsp.result;
                  cspl_pkg::SRC_T1:    t1_in = alu_rsp.result;
                  cspl_pkg::SRC_T2:    t2_in = alu_rsp.result;
                  cspl_pkg::SRC_S1:    s1_in = alu_rsp.result;
                  cspl_pkg::SRC_VAL:   val_in = alu_rsp.result;
                  cspl_pkg::SRC_SLOPE: slope_in = alu_rsp.result;
                  default: ;
               endcase
            end
         end
         cspl_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_int_in   = 8'(i_ff);
               rsp_out_in   = outside_ff;
               if (degen_ff) begin
                  rsp_val_in   = f0_ff[31:0];
                  rsp_slope_in = '0;
                  rsp_sat_in   = 1'b0;
               end else begin
                  rsp_sat_in = clip_ff;
                  if (val_ff > VMAX) begin
                     rsp_val_in = VMAX[31:0];
                     rsp_sat_in = 1'b1;
                  end else if (val_ff < VMIN) begin
                     rsp_val_in = VMIN[31:0];
                     rsp_sat_in = 1'b1;
                  end else begin
                     rsp_val_in = val_ff[31:0];
                  end
                  if (slope_ff > VMAX) begin
                     rsp_slope_in = VMAX[31:0];
                     rsp_sat_in   = 1'b1;
                  end else if (slope_ff < VMIN) begin
                     rsp_slope_in = VMIN[31:0];
                     rsp_sat_in   = 1'b1;
                  end else begin
                     rsp_slope_in = slope_ff[31:0];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cspl_pkg::ST_IDLE;
         knot_count_ff <= 9'd3;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         knot_count_ff <= knot_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      q_ff <= q_in;     gi_ff <= gi_in;   lo_ff <= lo_in;   hi_ff <= hi_in;
      mid_ff <= mid_in; i_ff <= i_in;     outside_ff <= outside_in;
      degen_ff <= degen_in; clip_ff <= clip_in; pc_ff <= pc_in;
      x_ff <= x_in;   h_ff <= h_in;   f0_ff <= f0_in; f1_ff <= f1_in;
      m0_ff <= m0_in; m1_ff <= m1_in; t_ff <= t_in;   x2h_ff <= x2h_in;
      x3h_ff <= x3h_in; xx_ff <= xx_in; xh_ff <= xh_in; a_ff <= a_in;
      c_ff <= c_in;   d_ff <= d_in;   bp_ff <= bp_in; ap_ff <= ap_in;
      cp_ff <= cp_in; dp_ff <= dp_in; t1_ff <= t1_in; t2_ff <= t2_in;
      s1_ff <= s1_in; val_ff <= val_in; slope_ff <= slope_in;
      rsp_val_ff <= rsp_val_in; rsp_slope_ff <= rsp_slope_in; rsp_int_ff <= rsp_int_in;
      rsp_out_ff <= rsp_out_in; rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_spline_value  = rsp_val_ff;
   assign rsp_spline_slope  = rsp_slope_ff;
   assign rsp_interval_used = rsp_int_ff;
   assign rsp_outside_grid  = rsp_out_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule
